@@ rtl/core/b91pe_pkg.sv @@
// Shared constants and transaction types for the base-91 position encoder.
`default_nettype none

package b91pe_pkg;

  // Coordinate units: 1/6000 degree
  localparam logic [12:0] UNITS_PER_DEG = 13'd6000;
  localparam logic [25:0] LAT_OFFSET    = 26'd540000;
  localparam logic [25:0] LAT_SPAN      = 26'd1080000;
  localparam logic [25:0] LON_OFFSET    = 26'd1080000;
  localparam logic [25:0] LON_SPAN      = 26'd2160000;

  // Hemisphere characters that mean a positive sign
  localparam logic [7:0] ASCII_N = 8'd78;
  localparam logic [7:0] ASCII_E = 8'd69;

  // Longitude scale; latitude uses this same scale on a doubled angle
  localparam logic [17:0] LON_SCALE   = 18'd190463;
  localparam logic [4:0]  SCALE_WHOLE = 5'(190463 / 6000);
  localparam logic [12:0] SCALE_FRAC  = 13'(190463 % 6000);

  // Base-91 weights and character offset
  localparam logic [19:0] B91_3       = 20'd753571;
  localparam logic [13:0] B91_2       = 14'd8281;
  localparam logic [6:0]  B91_1       = 7'd91;
  localparam logic [6:0]  CHAR_OFFSET = 7'd33;

  // Reciprocals for quotient estimates; the estimate is low by at most one
  localparam logic [31:0] RECIP_6000 = 32'((64'd1 << 32) / 64'd6000);
  localparam logic [31:0] RECIP_B3   = 32'((64'd1 << 32) / 64'd753571);
  localparam logic [31:0] RECIP_B2   = 32'((64'd1 << 32) / 64'd8281);
  localparam logic [31:0] RECIP_B1   = 32'((64'd1 << 32) / 64'd91);

  // Clamped, scaled angle in 1/6000 degree (latitude doubled)
  typedef struct packed {
    logic [21:0] u;
    logic        oor;
  } b91pe_angle_t;

  // Position value before splitting into digits
  typedef struct packed {
    logic [26:0] v;
    logic        oor;
  } b91pe_value_t;

  // Finished characters
  typedef struct packed {
    logic [6:0] c0;
    logic [6:0] c1;
    logic [6:0] c2;
    logic [6:0] c3;
    logic       oor;
  } b91pe_code_t;

endpackage

`default_nettype wire

@@ rtl/core/b91pe_front.sv @@
// Digit decode, coordinate assembly and span clamp: three pipeline stages.
`default_nettype none

module b91pe_front import b91pe_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic         action,
  input  logic [3:0]   deg_hundreds,
  input  logic [3:0]   deg_tens,
  input  logic [3:0]   deg_units,
  input  logic [3:0]   min_tens,
  input  logic [3:0]   min_units,
  input  logic [3:0]   frac_tens,
  input  logic [3:0]   frac_units,
  input  logic [7:0]   hemisphere,
  output logic         out_valid,
  input  logic         out_ready,
  output b91pe_angle_t out_data
);

  localparam int NS = 3;

  logic [NS-1:0] vld;
  logic [NS-1:0] en;

  // Stage enables: a stage loads when empty or when the next one loads
  always_comb begin
    en[NS-1] = !vld[NS-1] || out_ready;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld[NS-1];

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= in_valid;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // Stage 0: combine digits into degrees and minute hundredths
  logic [10:0] deg_c;
  logic [14:0] mf_c;
  logic        pos_c;
  logic [10:0] s0_deg;
  logic [14:0] s0_mf;
  logic        s0_lon;
  logic        s0_pos;

  always_comb begin
    deg_c = 11'(deg_tens) * 11'd10 + 11'(deg_units);
    if (action) deg_c = deg_c + 11'(deg_hundreds) * 11'd100;
    mf_c  = (15'(min_tens) * 15'd10 + 15'(min_units)) * 15'd100
          + 15'(frac_tens) * 15'd10 + 15'(frac_units);
    pos_c = action ? (hemisphere == ASCII_E) : (hemisphere == ASCII_N);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s0_deg <= deg_c;
      s0_mf  <= mf_c;
      s0_lon <= action;
      s0_pos <= pos_c;
    end
  end

  // Stage 1: coordinate in 1/6000 degree
  logic [23:0] s1_d;
  logic        s1_lon;
  logic        s1_pos;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_d   <= 24'(s0_deg) * 24'(UNITS_PER_DEG) + 24'(s0_mf);
      s1_lon <= s0_lon;
      s1_pos <= s0_pos;
    end
  end

  // Stage 2: offset, clamp to span, double latitude
  logic [25:0] off_c;
  logic [25:0] span_c;
  logic [25:0] t_c;
  logic [25:0] tc_c;
  logic        clamp_c;
  logic        sub_c;

  always_comb begin
    off_c   = s1_lon ? LON_OFFSET : LAT_OFFSET;
    span_c  = s1_lon ? LON_SPAN : LAT_SPAN;
    sub_c   = s1_lon ? !s1_pos : s1_pos;
    t_c     = sub_c ? off_c - 26'(s1_d) : off_c + 26'(s1_d);
    tc_c    = t_c;
    clamp_c = 1'b0;
    if (t_c[25]) begin
      tc_c    = '0;
      clamp_c = 1'b1;
    end else if (t_c > span_c) begin
      tc_c    = span_c;
      clamp_c = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      out_data.u   <= s1_lon ? tc_c[21:0] : {tc_c[20:0], 1'b0};
      out_data.oor <= clamp_c;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/b91pe_scale.sv @@
// Scaling of the clamped angle to the position value: six pipeline stages.
`default_nettype none

module b91pe_scale import b91pe_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  b91pe_angle_t in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output b91pe_value_t out_data
);

  localparam int NS = 6;

  logic [NS-1:0] vld;
  logic [NS-1:0] en;

  // Stage enables
  always_comb begin
    en[NS-1] = !vld[NS-1] || out_ready;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld[NS-1];

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= in_valid;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // Stage 0: estimate whole degrees, u / 6000
  logic [53:0] p0_c;
  logic [8:0]  s0_qe;
  logic [21:0] s0_u;
  logic        s0_oor;

  assign p0_c = 54'(in_data.u) * 54'(RECIP_6000);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s0_qe  <= p0_c[40:32];
      s0_u   <= in_data.u;
      s0_oor <= in_data.oor;
    end
  end

  // Stage 1: correct the estimate, keep the remainder
  logic [13:0] r0_c;
  logic [8:0]  s1_q;
  logic [12:0] s1_r;
  logic        s1_oor;

  assign r0_c = 14'(s0_u - 22'(22'(s0_qe) * 22'(UNITS_PER_DEG)));

  always_ff @(posedge clk) begin
    if (en[1]) begin
      if (r0_c >= 14'(UNITS_PER_DEG)) begin
        s1_q <= s0_qe + 9'd1;
        s1_r <= 13'(r0_c - 14'(UNITS_PER_DEG));
      end else begin
        s1_q <= s0_qe;
        s1_r <= 13'(r0_c);
      end
      s1_oor <= s0_oor;
    end
  end

  // Stage 2: whole part of the product and fractional numerator
  logic [24:0] s2_y;
  logic [26:0] s2_a;
  logic        s2_oor;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_y   <= 25'(s1_r) * 25'(SCALE_FRAC);
      s2_a   <= 27'(s1_q) * 27'(LON_SCALE) + 27'(s1_r) * 27'(SCALE_WHOLE);
      s2_oor <= s1_oor;
    end
  end

  // Stage 3: estimate y / 6000
  logic [56:0] p3_c;
  logic [12:0] s3_ye;
  logic [24:0] s3_y;
  logic [26:0] s3_a;
  logic        s3_oor;

  assign p3_c = 57'(s2_y) * 57'(RECIP_6000);

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s3_ye  <= p3_c[44:32];
      s3_y   <= s2_y;
      s3_a   <= s2_a;
      s3_oor <= s2_oor;
    end
  end

  // Stage 4: correct the fractional quotient
  logic [13:0] ry_c;
  logic [12:0] s4_q2;
  logic [26:0] s4_a;
  logic        s4_oor;

  assign ry_c = 14'(s3_y - 25'(25'(s3_ye) * 25'(UNITS_PER_DEG)));

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s4_q2  <= (ry_c >= 14'(UNITS_PER_DEG)) ? s3_ye + 13'd1 : s3_ye;
      s4_a   <= s3_a;
      s4_oor <= s3_oor;
    end
  end

  // Stage 5: sum the two parts
  always_ff @(posedge clk) begin
    if (en[5]) begin
      out_data.v   <= s4_a + 27'(s4_q2);
      out_data.oor <= s4_oor;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/b91pe_digits.sv @@
// Base-91 digit split of the position value: six pipeline stages.
`default_nettype none

module b91pe_digits import b91pe_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  b91pe_value_t in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output b91pe_code_t  out_data
);

  localparam int NS = 6;

  logic [NS-1:0] vld;
  logic [NS-1:0] en;

  // Stage enables
  always_comb begin
    en[NS-1] = !vld[NS-1] || out_ready;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld[NS-1];

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= in_valid;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // Stage 0: estimate the top digit
  logic [58:0] p0_c;
  logic [6:0]  s0_e;
  logic [26:0] s0_v;
  logic        s0_oor;

  assign p0_c = 59'(in_data.v) * 59'(RECIP_B3);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s0_e   <= p0_c[38:32];
      s0_v   <= in_data.v;
      s0_oor <= in_data.oor;
    end
  end

  // Stage 1: correct the top digit
  logic [20:0] r1_c;
  logic [6:0]  s1_d0;
  logic [19:0] s1_rem;
  logic        s1_oor;

  assign r1_c = 21'(s0_v - 27'(27'(s0_e) * 27'(B91_3)));

  always_ff @(posedge clk) begin
    if (en[1]) begin
      if (r1_c >= 21'(B91_3)) begin
        s1_d0  <= s0_e + 7'd1;
        s1_rem <= 20'(r1_c - 21'(B91_3));
      end else begin
        s1_d0  <= s0_e;
        s1_rem <= 20'(r1_c);
      end
      s1_oor <= s0_oor;
    end
  end

  // Stage 2: estimate the second digit
  logic [51:0] p2_c;
  logic [6:0]  s2_e;
  logic [6:0]  s2_d0;
  logic [19:0] s2_rem;
  logic        s2_oor;

  assign p2_c = 52'(s1_rem) * 52'(RECIP_B2);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_e   <= p2_c[38:32];
      s2_d0  <= s1_d0;
      s2_rem <= s1_rem;
      s2_oor <= s1_oor;
    end
  end

  // Stage 3: correct the second digit
  logic [14:0] r3_c;
  logic [6:0]  s3_d0;
  logic [6:0]  s3_d1;
  logic [13:0] s3_rem;
  logic        s3_oor;

  assign r3_c = 15'(s2_rem - 20'(20'(s2_e) * 20'(B91_2)));

  always_ff @(posedge clk) begin
    if (en[3]) begin
      if (r3_c >= 15'(B91_2)) begin
        s3_d1  <= s2_e + 7'd1;
        s3_rem <= 14'(r3_c - 15'(B91_2));
      end else begin
        s3_d1  <= s2_e;
        s3_rem <= 14'(r3_c);
      end
      s3_d0  <= s2_d0;
      s3_oor <= s2_oor;
    end
  end

  // Stage 4: estimate the third digit
  logic [45:0] p4_c;
  logic [6:0]  s4_e;
  logic [6:0]  s4_d0;
  logic [6:0]  s4_d1;
  logic [13:0] s4_rem;
  logic        s4_oor;

  assign p4_c = 46'(s3_rem) * 46'(RECIP_B1);

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s4_e   <= p4_c[38:32];
      s4_d0  <= s3_d0;
      s4_d1  <= s3_d1;
      s4_rem <= s3_rem;
      s4_oor <= s3_oor;
    end
  end

  // Stage 5: correct the third digit, remainder is the last; add the offset
  logic [7:0] r5_c;

  assign r5_c = 8'(s4_rem - 14'(14'(s4_e) * 14'(B91_1)));

  always_ff @(posedge clk) begin
    if (en[5]) begin
      if (r5_c >= 8'(B91_1)) begin
        out_data.c2 <= s4_e + 7'd1 + CHAR_OFFSET;
        out_data.c3 <= 7'(r5_c - 8'(B91_1)) + CHAR_OFFSET;
      end else begin
        out_data.c2 <= s4_e + CHAR_OFFSET;
        out_data.c3 <= 7'(r5_c) + CHAR_OFFSET;
      end
      out_data.c0  <= s4_d0 + CHAR_OFFSET;
      out_data.c1  <= s4_d1 + CHAR_OFFSET;
      out_data.oor <= s4_oor;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/base91_position_encoder.sv @@
// Throughput: one transaction per cycle; fifteen register stages, each with a
// valid bit, and a stage holds only while the stage after it is full and stalled.
// Reset (synchronous, active high) empties every stage; payload is not cleared.
// Top level of the base-91 position encoder.
`default_nettype none

module base91_position_encoder import b91pe_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       action,
  input  logic [3:0] deg_hundreds,
  input  logic [3:0] deg_tens,
  input  logic [3:0] deg_units,
  input  logic [3:0] min_tens,
  input  logic [3:0] min_units,
  input  logic [3:0] frac_tens,
  input  logic [3:0] frac_units,
  input  logic [7:0] hemisphere,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [6:0] code_digit0,
  output logic [6:0] code_digit1,
  output logic [6:0] code_digit2,
  output logic [6:0] code_digit3,
  output logic       out_of_range
);

  logic         ang_valid;
  logic         ang_ready;
  b91pe_angle_t ang_data;
  logic         val_valid;
  logic         val_ready;
  b91pe_value_t val_data;
  b91pe_code_t  code_data;

  // Decode and clamp
  b91pe_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .action       (action),
    .deg_hundreds (deg_hundreds),
    .deg_tens     (deg_tens),
    .deg_units    (deg_units),
    .min_tens     (min_tens),
    .min_units    (min_units),
    .frac_tens    (frac_tens),
    .frac_units   (frac_units),
    .hemisphere   (hemisphere),
    .out_valid    (ang_valid),
    .out_ready    (ang_ready),
    .out_data     (ang_data)
  );

  // Scale to the position value
  b91pe_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (ang_valid),
    .in_ready  (ang_ready),
    .in_data   (ang_data),
    .out_valid (val_valid),
    .out_ready (val_ready),
    .out_data  (val_data)
  );

  // Split into characters
  b91pe_digits u_digits (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (val_valid),
    .in_ready  (val_ready),
    .in_data   (val_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (code_data)
  );

  assign code_digit0  = code_data.c0;
  assign code_digit1  = code_data.c1;
  assign code_digit2  = code_data.c2;
  assign code_digit3  = code_data.c3;
  assign out_of_range = code_data.oor;

`ifndef ASSERT_OFF
  // Every character lies in the base-91 alphabet
  a_digit_span: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (code_digit0 >= 7'd33 && code_digit0 <= 7'd123 &&
                   code_digit1 >= 7'd33 && code_digit1 <= 7'd123 &&
                   code_digit2 >= 7'd33 && code_digit2 <= 7'd123 &&
                   code_digit3 >= 7'd33 && code_digit3 <= 7'd123))
    else $error("base-91 character outside its alphabet");

  // A clamped coordinate lands on one end of the span
  a_clamp_ends: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_of_range) |->
      ((code_digit0 == 7'd33 && code_digit1 == 7'd33 &&
        code_digit2 == 7'd33 && code_digit3 == 7'd33) ||
       (code_digit0 == 7'd123 && code_digit1 == 7'd123 &&
        code_digit2 == 7'd33 && code_digit3 == 7'd33)))
    else $error("clamped coordinate not at a span end");

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result presented straight after reset");
`endif

endmodule

`default_nettype wire

@@ test/tb.sv @@
// Self-checking testbench for the base-91 position encoder.
`timescale 1ns / 100ps

module tb;
  import b91pe_pkg::*;

  localparam logic ACT_LAT = 1'b0;
  localparam logic ACT_LON = 1'b1;
  localparam logic [7:0] HEMI_S = 8'd83;
  localparam logic [7:0] HEMI_W = 8'd87;
  localparam longint LAT_SCALE = 380926;
  localparam int ITEMS_PER_PHASE = 150;
  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    logic       action;
    logic [3:0] hun;
    logic [3:0] ten;
    logic [3:0] uni;
    logic [3:0] mt;
    logic [3:0] mu;
    logic [3:0] ft;
    logic [3:0] fu;
    logic [7:0] hemi;
  } coord_t;

  // Tracks the codes owed by the encoder, oldest first
  class position_code_tracker;
    b91pe_code_t pending_codes[$];
    int mismatches = 0;

    function int pending();
      return pending_codes.size();
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    // Work out the four characters and the clamp flag for one coordinate
    function b91pe_code_t encode_coord(coord_t c);
      longint deg, d, t, span, scale, v;
      b91pe_code_t code;
      code.oor = 1'b0;
      deg = longint'(c.ten) * 10 + longint'(c.uni);
      if (c.action == ACT_LON)
        deg += longint'(c.hun) * 100;
      d = deg * longint'(UNITS_PER_DEG) + (longint'(c.mt) * 10 + longint'(c.mu)) * 100
          + longint'(c.ft) * 10 + longint'(c.fu);
      if (c.action == ACT_LON) begin
        t = (c.hemi == ASCII_E) ? longint'(LON_OFFSET) + d : longint'(LON_OFFSET) - d;
        span = longint'(LON_SPAN);
        scale = longint'(LON_SCALE);
      end else begin
        t = (c.hemi == ASCII_N) ? longint'(LAT_OFFSET) - d : longint'(LAT_OFFSET) + d;
        span = longint'(LAT_SPAN);
        scale = LAT_SCALE;
      end
      // Clamp to the valid span and flag it
      if (t < 0) begin
        t = 0;
        code.oor = 1'b1;
      end else if (t > span) begin
        t = span;
        code.oor = 1'b1;
      end
      v = (t * scale) / longint'(UNITS_PER_DEG);
      code.c0 = 7'((v / longint'(B91_3)) + longint'(CHAR_OFFSET));
      code.c1 = 7'(((v % longint'(B91_3)) / longint'(B91_2)) + longint'(CHAR_OFFSET));
      code.c2 = 7'(((v % longint'(B91_2)) / longint'(B91_1)) + longint'(CHAR_OFFSET));
      code.c3 = 7'((v % longint'(B91_1)) + longint'(CHAR_OFFSET));
      return code;
    endfunction

    function void note_coord(coord_t c);
      pending_codes.push_back(encode_coord(c));
    endfunction

    task compare_field(string name, int got, int want);
      if (got != want)
        report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    task check_code(b91pe_code_t got);
      b91pe_code_t want;
      if (pending_codes.size() == 0) begin
        report_mismatch("result with no transaction outstanding");
        return;
      end
      want = pending_codes.pop_front();
      compare_field("code_digit0", got.c0, want.c0);
      compare_field("code_digit1", got.c1, want.c1);
      compare_field("code_digit2", got.c2, want.c2);
      compare_field("code_digit3", got.c3, want.c3);
      compare_field("out_of_range", got.oor, want.oor);
    endtask
  endclass

  logic       clk;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       action = ACT_LAT;
  logic [3:0] deg_hundreds = '0;
  logic [3:0] deg_tens = '0;
  logic [3:0] deg_units = '0;
  logic [3:0] min_tens = '0;
  logic [3:0] min_units = '0;
  logic [3:0] frac_tens = '0;
  logic [3:0] frac_units = '0;
  logic [7:0] hemisphere = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [6:0] code_digit0;
  logic [6:0] code_digit1;
  logic [6:0] code_digit2;
  logic [6:0] code_digit3;
  logic       out_of_range;

  int send_gap_pct = 27;
  int hold_pct = 61;
  int idle_cycles = 0;

  position_code_tracker tracker = new();

  base91_position_encoder uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .action(action),
    .deg_hundreds(deg_hundreds),
    .deg_tens(deg_tens),
    .deg_units(deg_units),
    .min_tens(min_tens),
    .min_units(min_units),
    .frac_tens(frac_tens),
    .frac_units(frac_units),
    .hemisphere(hemisphere),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .code_digit0(code_digit0),
    .code_digit1(code_digit1),
    .code_digit2(code_digit2),
    .code_digit3(code_digit3),
    .out_of_range(out_of_range)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Stall the result side at random
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= hold_pct);
  end

  // Check each result transaction
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      tracker.check_code({code_digit0, code_digit1, code_digit2, code_digit3, out_of_range});
  end

  // Abort when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready))
      idle_cycles <= 0;
    else if (idle_cycles >= IDLE_LIMIT) begin
      $display("[%0t] watchdog: no transaction for %0d cycles", $time, IDLE_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  function automatic coord_t mk(logic act, int hun, int ten, int uni, int mt, int mu,
                                int ft, int fu, logic [7:0] hemi);
    coord_t c;
    c.action = act;
    c.hun = 4'(hun);
    c.ten = 4'(ten);
    c.uni = 4'(uni);
    c.mt = 4'(mt);
    c.mu = 4'(mu);
    c.ft = 4'(ft);
    c.fu = 4'(fu);
    c.hemi = hemi;
    return c;
  endfunction

  // Offer one coordinate, idling first at random, and hold until taken
  task automatic send_coord(coord_t c);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= c.action;
    deg_hundreds <= c.hun;
    deg_tens <= c.ten;
    deg_units <= c.uni;
    min_tens <= c.mt;
    min_units <= c.mu;
    frac_tens <= c.ft;
    frac_units <= c.fu;
    hemisphere <= c.hemi;
    do @(posedge clk); while (!in_ready);
    tracker.note_coord(c);
  endtask

  // Drop valid and hold until every owed result is back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  task automatic run_random(int count);
    coord_t c;
    int deg, mins, frac, r;
    logic [7:0] letters[4];
    letters = '{ASCII_N, HEMI_S, ASCII_E, HEMI_W};
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      c.action = 1'($urandom_range(1));
      c.hemi = letters[$urandom_range(3)];
      if (r < 70) begin
        // Plausible coordinates, some pushed onto the poles and the antimeridian
        if (r < 55) begin
          deg = (c.action == ACT_LON) ? $urandom_range(179) : $urandom_range(89);
          mins = $urandom_range(59);
          frac = $urandom_range(99);
        end else begin
          deg = ((c.action == ACT_LON) ? 180 : 90) - $urandom_range(1);
          mins = $urandom_range(1);
          frac = $urandom_range(2);
        end
        c.hun = (c.action == ACT_LON) ? 4'(deg / 100) : 4'($urandom_range(15));
        c.ten = 4'((deg / 10) % 10);
        c.uni = 4'(deg % 10);
        c.mt = 4'(mins / 10);
        c.mu = 4'(mins % 10);
        c.ft = 4'(frac / 10);
        c.fu = 4'(frac % 10);
      end else if (r < 85) begin
        // Any decimal digits
        c = mk(c.action, $urandom_range(9), $urandom_range(9), $urandom_range(9),
               $urandom_range(9), $urandom_range(9), $urandom_range(9),
               $urandom_range(9), c.hemi);
      end else begin
        // Raw nibbles and any byte
        c = mk(c.action, $urandom_range(15), $urandom_range(15), $urandom_range(15),
               $urandom_range(15), $urandom_range(15), $urandom_range(15),
               $urandom_range(15), 8'($urandom_range(255)));
      end
      send_coord(c);
    end
  endtask

  initial begin
    coord_t directed[$];
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Latitude: equator, both poles, overshoot, stray hundreds digit, odd bytes
    directed.push_back(mk(ACT_LAT, 0, 0, 0, 0, 0, 0, 0, ASCII_N));
    directed.push_back(mk(ACT_LAT, 0, 9, 0, 0, 0, 0, 0, ASCII_N));
    directed.push_back(mk(ACT_LAT, 0, 9, 0, 0, 0, 0, 0, HEMI_S));
    directed.push_back(mk(ACT_LAT, 0, 9, 0, 0, 0, 0, 1, ASCII_N));
    directed.push_back(mk(ACT_LAT, 0, 9, 0, 0, 0, 0, 1, HEMI_S));
    directed.push_back(mk(ACT_LAT, 15, 15, 15, 15, 15, 15, 15, ASCII_N));
    directed.push_back(mk(ACT_LAT, 15, 15, 15, 15, 15, 15, 15, HEMI_S));
    directed.push_back(mk(ACT_LAT, 15, 4, 5, 3, 0, 5, 0, ASCII_N));
    directed.push_back(mk(ACT_LAT, 0, 4, 8, 0, 7, 3, 8, ASCII_N));
    directed.push_back(mk(ACT_LAT, 0, 3, 3, 5, 1, 3, 5, HEMI_S));
    directed.push_back(mk(ACT_LAT, 0, 1, 2, 3, 4, 5, 6, ASCII_E));
    directed.push_back(mk(ACT_LAT, 0, 1, 2, 3, 4, 5, 6, 8'h00));
    directed.push_back(mk(ACT_LAT, 0, 1, 2, 3, 4, 5, 6, 8'hFF));
    directed.push_back(mk(ACT_LAT, 0, 1, 2, 3, 4, 5, 6, 8'h6E));
    // Longitude: meridian, antimeridian from both sides, overshoot, odd bytes
    directed.push_back(mk(ACT_LON, 0, 0, 0, 0, 0, 0, 0, ASCII_E));
    directed.push_back(mk(ACT_LON, 1, 8, 0, 0, 0, 0, 0, ASCII_E));
    directed.push_back(mk(ACT_LON, 1, 8, 0, 0, 0, 0, 0, HEMI_W));
    directed.push_back(mk(ACT_LON, 1, 8, 0, 0, 0, 0, 1, ASCII_E));
    directed.push_back(mk(ACT_LON, 1, 8, 0, 0, 0, 0, 1, HEMI_W));
    directed.push_back(mk(ACT_LON, 0, 1, 1, 3, 1, 6, 3, ASCII_E));
    directed.push_back(mk(ACT_LON, 1, 2, 2, 2, 5, 0, 0, HEMI_W));
    directed.push_back(mk(ACT_LON, 0, 9, 9, 5, 9, 9, 9, HEMI_W));
    directed.push_back(mk(ACT_LON, 0, 0, 5, 0, 0, 0, 0, ASCII_N));
    directed.push_back(mk(ACT_LON, 0, 0, 5, 0, 0, 0, 0, 8'h65));
    directed.push_back(mk(ACT_LON, 15, 15, 15, 15, 15, 15, 15, ASCII_E));
    directed.push_back(mk(ACT_LON, 15, 15, 15, 15, 15, 15, 15, 8'h00));
    foreach (directed[i]) send_coord(directed[i]);

    // Sender idles lightly, result side stalls heavily
    run_random(ITEMS_PER_PHASE);
    drain_results();

    // Swap the idle rates
    send_gap_pct = 61;
    hold_pct = 27;
    run_random(ITEMS_PER_PHASE);
    drain_results();

    // Full rate on both sides
    send_gap_pct = 0;
    hold_pct = 0;
    run_random(ITEMS_PER_PHASE);
    drain_results();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.pending() != 0)
      tracker.report_mismatch($sformatf("%0d results never arrived", tracker.pending()));
    if (tracker.mismatches == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/b91pe_pkg.sv
rtl/core/b91pe_front.sv
rtl/core/b91pe_scale.sv
rtl/core/b91pe_digits.sv
rtl/core/base91_position_encoder.sv
test/tb.sv
